@@ sv/bitmap_block_inode_allocator_macros.svh @@
// Assertion helpers shared by the RTL that checks itself.
`ifndef BITMAP_BLOCK_INODE_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_INODE_ALLOCATOR_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define BBIA_ASSERT_NOW(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Condition that must hold in the cycle after the antecedent.
`define BBIA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/bbia_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bbia_pkg;

	// Bitmap memory word and field widths
	localparam int WORD_W    = 32;
	localparam int BIT_W     = 5;
	localparam int NUM_W     = 11;
	localparam int ICNT_W    = 9;
	localparam int FIRST_W   = 8;
	localparam int ACT_W     = 2;
	localparam int WIDX_W    = NUM_W - BIT_W;
	localparam int CFG_IDX_W = 2;
	// Wide enough for the largest map depth
	localparam int CMP_W     = 17;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_MARK_USED = 2'd0;
	localparam logic [ACT_W-1:0] ACT_MARK_FREE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FIND      = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INODE_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_INODE = 2'd2;

	// Register reset values
	localparam logic [NUM_W-1:0]   BLOCK_COUNT_RST = 11'd128;
	localparam logic [ICNT_W-1:0]  INODE_COUNT_RST = 9'd32;
	localparam logic [FIRST_W-1:0] FIRST_INODE_RST = 8'd11;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MARK,
		ST_FIND,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [NUM_W-1:0]   block_count;
		logic [ICNT_W-1:0]  inode_count;
		logic [FIRST_W-1:0] first_inode;
		logic               reload_blk;
		logic               reload_ino;
	} cfg_t;

endpackage
`default_nettype wire

@@ sv/bbia_map_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bbia_map_ram
	import bbia_pkg::*;
#(
	parameter int DEPTH = 32,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WORD_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	// Write one word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held while idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ sv/bbia_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bbia_ctrl
	import bbia_pkg::*;
#(
	parameter int MAX_BLOCKS = 1024,
	parameter int MAX_INODES = 256,
	parameter int ADDR_W     = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [ACT_W-1:0]  action,
	input  wire logic              map_select,
	input  wire logic [NUM_W-1:0]  item_number,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [NUM_W-1:0]  found_number,
	output logic                   bit_was_set,
	output logic                   out_of_range,
	output logic      [NUM_W-1:0]  free_blocks,
	output logic      [ICNT_W-1:0] free_inodes,
	output logic                   mem_re,
	output logic      [ADDR_W-1:0] mem_raddr,
	output logic                   mem_we_blk,
	output logic                   mem_we_ino,
	output logic      [ADDR_W-1:0] mem_waddr,
	output logic      [WORD_W-1:0] mem_wdata,
	input  wire logic [WORD_W-1:0] blk_rdata,
	input  wire logic [WORD_W-1:0] ino_rdata
);

	localparam int BLK_WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int INO_WORDS = (MAX_INODES + WORD_W - 1) / WORD_W;
	localparam int MAX_WORDS = (BLK_WORDS > INO_WORDS) ? BLK_WORDS : INO_WORDS;
	localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(MAX_WORDS - 1);
	localparam logic [ADDR_W:0]   BLK_WLIM  = (ADDR_W + 1)'(BLK_WORDS);
	localparam logic [ADDR_W:0]   INO_WLIM  = (ADDR_W + 1)'(INO_WORDS);
	localparam logic [CMP_W-1:0]  MAX_BLK_V = CMP_W'(MAX_BLOCKS);
	localparam logic [CMP_W-1:0]  MAX_INO_V = CMP_W'(MAX_INODES);

	state_t state_q, state_d;

	logic [ADDR_W-1:0] clr_q;
	logic              map_q;
	logic              set_q;
	logic [BIT_W-1:0]  bit_q;
	logic [WIDX_W-1:0] word_q;
	logic [NUM_W-1:0]  start_q;
	logic [NUM_W-1:0]  last_q;
	logic [WIDX_W-1:0] rd_w_q;
	logic              chk_v_s1;
	logic [WIDX_W-1:0] chk_w_s1;
	logic [NUM_W-1:0]  found_q;
	logic              was_q;
	logic              oor_q;
	logic [NUM_W-1:0]  free_blk_q;
	logic [ICNT_W-1:0] free_ino_q;
	logic              out_valid_q;
	logic [NUM_W-1:0]  found_out_q;
	logic              was_out_q;
	logic              oor_out_q;
	logic [NUM_W-1:0]  free_blk_out_q;
	logic [ICNT_W-1:0] free_ino_out_q;

	logic              accept;
	logic              out_free;
	logic [NUM_W-1:0]  eff_blk;
	logic [NUM_W-1:0]  eff_ino;
	logic [NUM_W-1:0]  sel_eff;
	logic              is_mark;
	logic [NUM_W-1:0]  num_m1;
	logic              in_oor;
	logic              in_touch;
	logic [NUM_W-1:0]  find_start;
	logic              find_empty;
	logic              issue;
	logic [WORD_W-1:0] rd_word;
	logic [WORD_W-1:0] bit_sel;
	logic              old_bit;
	logic [WORD_W-1:0] mark_word;
	logic [WORD_W-1:0] free_bits;
	logic [WORD_W-1:0] lowest;
	logic [BIT_W-1:0]  free_pos;
	logic              hit;
	logic              scan_end;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Decode the incoming word against the effective map size
	always_comb begin
		eff_blk = ({{(CMP_W - NUM_W){1'b0}}, cfg.block_count} > MAX_BLK_V) ?
			MAX_BLK_V[NUM_W-1:0] : cfg.block_count;
		eff_ino = ({{(CMP_W - ICNT_W){1'b0}}, cfg.inode_count} > MAX_INO_V) ?
			MAX_INO_V[NUM_W-1:0] : NUM_W'(cfg.inode_count);
		sel_eff    = map_select ? eff_ino : eff_blk;
		is_mark    = (action == ACT_MARK_USED) || (action == ACT_MARK_FREE);
		num_m1     = item_number - NUM_W'(1);
		in_oor     = is_mark && (item_number != '0) && (item_number > sel_eff);
		in_touch   = is_mark && (item_number != '0) && !in_oor;
		find_start = map_select ? NUM_W'(cfg.first_inode) : '0;
		find_empty = find_start >= sel_eff;
	end

	// Read-modify-write of the marked bit
	always_comb begin
		rd_word   = map_q ? ino_rdata : blk_rdata;
		bit_sel   = WORD_W'(1) << bit_q;
		old_bit   = |(rd_word & bit_sel);
		mark_word = set_q ? (rd_word | bit_sel) : (rd_word & ~bit_sel);
	end

	// Find the lowest clear bit inside the search window of this word
	always_comb begin
		for (int j = 0; j < WORD_W; j++) begin
			free_bits[j] = !rd_word[j]
				&& !((chk_w_s1 == start_q[NUM_W-1:BIT_W]) && (BIT_W'(j) < start_q[BIT_W-1:0]))
				&& !((chk_w_s1 == last_q[NUM_W-1:BIT_W]) && (BIT_W'(j) > last_q[BIT_W-1:0]));
		end
		lowest   = free_bits & (~free_bits + WORD_W'(1));
		free_pos = '0;
		for (int j = 0; j < WORD_W; j++) begin
			if (lowest[j]) begin
				free_pos = free_pos | BIT_W'(j);
			end
		end
		hit      = |free_bits;
		scan_end = chk_v_s1 && (hit || (chk_w_s1 == last_q[NUM_W-1:BIT_W]));
		issue    = (state_q == ST_FIND) && (rd_w_q <= last_q[NUM_W-1:BIT_W]);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (in_touch) begin
						state_d = ST_MARK;
					end else if ((action == ACT_FIND) && !find_empty) begin
						state_d = ST_FIND;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_MARK: begin
				state_d = ST_RESP;
			end
			ST_FIND: begin
				if (scan_end) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// Handshake and memory port drive
	always_comb begin
		in_ready   = 1'b0;
		mem_re     = 1'b0;
		mem_raddr  = ADDR_W'(num_m1[NUM_W-1:BIT_W]);
		mem_we_blk = 1'b0;
		mem_we_ino = 1'b0;
		mem_waddr  = ADDR_W'(word_q);
		mem_wdata  = mark_word;
		case (state_q)
			ST_CLEAR: begin
				mem_we_blk = {1'b0, clr_q} < BLK_WLIM;
				mem_we_ino = {1'b0, clr_q} < INO_WLIM;
				mem_waddr  = clr_q;
				mem_wdata  = '0;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				mem_re   = accept && in_touch;
			end
			ST_MARK: begin
				mem_we_blk = !map_q;
				mem_we_ino = map_q;
			end
			ST_FIND: begin
				mem_re    = issue;
				mem_raddr = ADDR_W'(rd_w_q);
			end
			ST_RESP: begin
				mem_re = 1'b0;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// State and clear sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			chk_v_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			chk_v_s1 <= issue;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
		end
	end

	// Latch the word and track the scan
	always_ff @(posedge clk) begin
		if (accept) begin
			map_q   <= map_select;
			set_q   <= action == ACT_MARK_USED;
			bit_q   <= num_m1[BIT_W-1:0];
			word_q  <= num_m1[NUM_W-1:BIT_W];
			start_q <= find_start;
			last_q  <= sel_eff - NUM_W'(1);
			rd_w_q  <= find_start[NUM_W-1:BIT_W];
			found_q <= '0;
			was_q   <= 1'b0;
			oor_q   <= in_oor;
		end else begin
			if (issue) begin
				rd_w_q <= rd_w_q + WIDX_W'(1);
			end
			if ((state_q == ST_FIND) && scan_end && hit) begin
				found_q <= {chk_w_s1, free_pos} + NUM_W'(1);
			end
			if (state_q == ST_MARK) begin
				was_q <= old_bit;
			end
		end
		chk_w_s1 <= rd_w_q;
	end

	// Free counters: reload on count write, adjust when a bit flips
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_blk_q <= BLOCK_COUNT_RST;
			free_ino_q <= INODE_COUNT_RST;
		end else begin
			if (cfg.reload_blk) begin
				free_blk_q <= cfg.block_count;
			end else if ((state_q == ST_MARK) && !map_q) begin
				if (set_q && !old_bit && (free_blk_q != '0)) begin
					free_blk_q <= free_blk_q - NUM_W'(1);
				end else if (!set_q && old_bit && (free_blk_q != '1)) begin
					free_blk_q <= free_blk_q + NUM_W'(1);
				end
			end
			if (cfg.reload_ino) begin
				free_ino_q <= cfg.inode_count;
			end else if ((state_q == ST_MARK) && map_q) begin
				if (set_q && !old_bit && (free_ino_q != '0)) begin
					free_ino_q <= free_ino_q - ICNT_W'(1);
				end else if (!set_q && old_bit && (free_ino_q != '1)) begin
					free_ino_q <= free_ino_q + ICNT_W'(1);
				end
			end
		end
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_RESP) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RESP) && out_free) begin
			found_out_q    <= found_q;
			was_out_q      <= was_q;
			oor_out_q      <= oor_q;
			free_blk_out_q <= free_blk_q;
			free_ino_out_q <= free_ino_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign found_number = found_out_q;
	assign bit_was_set  = was_out_q;
	assign out_of_range = oor_out_q;
	assign free_blocks  = free_blk_out_q;
	assign free_inodes  = free_ino_out_q;

endmodule
`default_nettype wire

@@ sv/bitmap_block_inode_allocator.sv @@
// Block and inode bitmap allocator, first fit.
// Input channel (in_valid/in_ready) takes one word: action, map_select and
// item_number. Output channel (out_valid/out_ready) returns one word per input
// word: found_number, bit_was_set, out_of_range and both free counters.
// Configuration: cfg_we/cfg_index/cfg_wdata write block_count, inode_count and
// first_usable_inode_index; a count write reloads its free counter through a
// registered reload strobe. Each map sits in a memory of 32-bit words with
// registered reads. A no-op, a zero or out-of-range mark and a find with an
// empty window go straight to the response state; a mark reads its word, then
// writes it back; a find reads one word per cycle until it meets a clear bit or
// the last word of its window. One word is in flight at a time: in_ready
// returns as the result is loaded into the output register.
// After reset both maps are cleared one word per cycle, max(MAX_BLOCKS,
// MAX_INODES) / 32 words (32 by default); in_ready stays low
// during that pass. Counters and registers reset to 128, 32 and 11.
// The next word is accepted while a result waits in the output register; if
// the receiver stalls, the following result waits in its last state until the
// output register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_block_inode_allocator_macros.svh"
module bitmap_block_inode_allocator
	import bbia_pkg::*;
#(
	parameter int MAX_BLOCKS = 1024,
	parameter int MAX_INODES = 256
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [NUM_W-1:0]     cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [ACT_W-1:0]     action,
	input  wire logic                 map_select,
	input  wire logic [NUM_W-1:0]     item_number,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [NUM_W-1:0]     found_number,
	output logic                      bit_was_set,
	output logic                      out_of_range,
	output logic      [NUM_W-1:0]     free_blocks,
	output logic      [ICNT_W-1:0]    free_inodes
);

	localparam int BLK_WORDS  = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int INO_WORDS  = (MAX_INODES + WORD_W - 1) / WORD_W;
	localparam int MAX_WORDS  = (BLK_WORDS > INO_WORDS) ? BLK_WORDS : INO_WORDS;
	localparam int ADDR_W     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int BLK_ADDR_W = (BLK_WORDS > 1) ? $clog2(BLK_WORDS) : 1;
	localparam int INO_ADDR_W = (INO_WORDS > 1) ? $clog2(INO_WORDS) : 1;

	logic [NUM_W-1:0]   block_count_q;
	logic [ICNT_W-1:0]  inode_count_q;
	logic [FIRST_W-1:0] first_inode_q;
	logic               reload_blk_q;
	logic               reload_ino_q;
	cfg_t               cfg;

	logic               mem_re;
	logic [ADDR_W-1:0]  mem_raddr;
	logic               mem_we_blk;
	logic               mem_we_ino;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [WORD_W-1:0]  mem_wdata;
	logic [WORD_W-1:0]  blk_rdata;
	logic [WORD_W-1:0]  ino_rdata;

	// Configuration registers; hold a reload strobe for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= BLOCK_COUNT_RST;
			inode_count_q <= INODE_COUNT_RST;
			first_inode_q <= FIRST_INODE_RST;
			reload_blk_q  <= 1'b0;
			reload_ino_q  <= 1'b0;
		end else begin
			reload_blk_q <= cfg_we && (cfg_index == REG_BLOCK_COUNT);
			reload_ino_q <= cfg_we && (cfg_index == REG_INODE_COUNT);
			if (cfg_we) begin
				case (cfg_index)
					REG_BLOCK_COUNT: begin
						block_count_q <= cfg_wdata;
					end
					REG_INODE_COUNT: begin
						inode_count_q <= cfg_wdata[ICNT_W-1:0];
					end
					REG_FIRST_INODE: begin
						first_inode_q <= cfg_wdata[FIRST_W-1:0];
					end
					default: begin
						first_inode_q <= first_inode_q;
					end
				endcase
			end
		end
	end

	always_comb begin
		cfg.block_count = block_count_q;
		cfg.inode_count = inode_count_q;
		cfg.first_inode = first_inode_q;
		cfg.reload_blk  = reload_blk_q;
		cfg.reload_ino  = reload_ino_q;
	end

	bbia_ctrl #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.MAX_INODES (MAX_INODES),
		.ADDR_W     (ADDR_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.map_select   (map_select),
		.item_number  (item_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found_number (found_number),
		.bit_was_set  (bit_was_set),
		.out_of_range (out_of_range),
		.free_blocks  (free_blocks),
		.free_inodes  (free_inodes),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_we_blk   (mem_we_blk),
		.mem_we_ino   (mem_we_ino),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.blk_rdata    (blk_rdata),
		.ino_rdata    (ino_rdata)
	);

	bbia_map_ram #(
		.DEPTH (BLK_WORDS)
	) u_blk_ram (
		.clk   (clk),
		.we    (mem_we_blk),
		.waddr (mem_waddr[BLK_ADDR_W-1:0]),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr[BLK_ADDR_W-1:0]),
		.rdata (blk_rdata)
	);

	bbia_map_ram #(
		.DEPTH (INO_WORDS)
	) u_ino_ram (
		.clk   (clk),
		.we    (mem_we_ino),
		.waddr (mem_waddr[INO_ADDR_W-1:0]),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr[INO_ADDR_W-1:0]),
		.rdata (ino_rdata)
	);

	`BBIA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input still ready after accepting a word")
	`BBIA_ASSERT_NOW(a_write_only_busy, !(mem_we_blk || mem_we_ino) || !in_ready, "bitmap written while idle")
	`BBIA_ASSERT_NOW(a_find_result_clean, !out_valid || (found_number == '0) || (!bit_was_set && !out_of_range), "find result carries mark flags")

endmodule
`default_nettype wire

@@ tb/tb_bitmap_block_inode_allocator.sv @@
`timescale 1ns / 1ps
module tb_bitmap_block_inode_allocator;
	import bbia_pkg::*;

	localparam int BLOCK_DEPTH = 1024;
	localparam int INODE_DEPTH = 256;
	localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int REPORT_LIMIT = 10;
	localparam int RANDOM_PHASES = 8;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic             sel;
		logic [NUM_W-1:0] num;
	} alloc_req_t;

	typedef struct packed {
		logic [NUM_W-1:0]  found;
		logic              was_set;
		logic              oor;
		logic [NUM_W-1:0]  free_blk;
		logic [ICNT_W-1:0] free_ino;
	} alloc_resp_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [NUM_W-1:0]     cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [ACT_W-1:0]     action = '0;
	logic                 map_select = 1'b0;
	logic [NUM_W-1:0]     item_number = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [NUM_W-1:0]     found_number;
	logic                 bit_was_set;
	logic                 out_of_range;
	logic [NUM_W-1:0]     free_blocks;
	logic [ICNT_W-1:0]    free_inodes;

	// Shadow copy of both maps, counters and registers
	bit                block_used [BLOCK_DEPTH];
	bit                inode_used [INODE_DEPTH];
	logic [NUM_W-1:0]  block_count_q = BLOCK_COUNT_RST;
	logic [ICNT_W-1:0] inode_count_q = INODE_COUNT_RST;
	logic [FIRST_W-1:0] first_inode_q = FIRST_INODE_RST;
	logic [NUM_W-1:0]  free_blocks_q = BLOCK_COUNT_RST;
	logic [ICNT_W-1:0] free_inodes_q = INODE_COUNT_RST;

	alloc_req_t  request_queue [$];
	alloc_resp_t replies_due [$];
	alloc_resp_t want;
	alloc_req_t  next_req;
	int          mismatch_count = 0;
	int          reply_index = 0;

	// Sender burst state
	int burst_left = 0;
	int gap_left = 0;
	bit send_now;

	// Receiver stall state
	bit hold_request = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;
	int ready_mode = 0;
	int mode_left = 0;
	bit ready_next;

	bitmap_block_inode_allocator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.map_select   (map_select),
		.item_number  (item_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found_number (found_number),
		.bit_was_set  (bit_was_set),
		.out_of_range (out_of_range),
		.free_blocks  (free_blocks),
		.free_inodes  (free_inodes)
	);

	always #1 clk = ~clk;

	// Effective map size: count register clipped to the map depth
	function automatic int map_span(bit sel);
		if (sel) begin
			return (inode_count_q > INODE_DEPTH) ? INODE_DEPTH : int'(inode_count_q);
		end
		return (block_count_q > BLOCK_DEPTH) ? BLOCK_DEPTH : int'(block_count_q);
	endfunction

	// Apply one request to the shadow state and return the reply it must produce
	function automatic alloc_resp_t apply_request(alloc_req_t rq);
		alloc_resp_t rsp;
		int          span;
		int          k;
		bit          prev;
		rsp = '0;
		span = map_span(rq.sel);
		if (rq.act == ACT_MARK_USED || rq.act == ACT_MARK_FREE) begin
			if (rq.num != 0) begin
				if (rq.num > span) begin
					rsp.oor = 1'b1;
				end else begin
					prev = rq.sel ? inode_used[rq.num - 1] : block_used[rq.num - 1];
					rsp.was_set = prev;
					// counters move only on a real flip, and saturate at both ends
					if (rq.act == ACT_MARK_USED && !prev) begin
						if (rq.sel && free_inodes_q != 0)
							free_inodes_q = free_inodes_q - 1'b1;
						else if (!rq.sel && free_blocks_q != 0)
							free_blocks_q = free_blocks_q - 1'b1;
					end else if (rq.act == ACT_MARK_FREE && prev) begin
						if (rq.sel && free_inodes_q != '1)
							free_inodes_q = free_inodes_q + 1'b1;
						else if (!rq.sel && free_blocks_q != '1)
							free_blocks_q = free_blocks_q + 1'b1;
					end
					if (rq.sel)
						inode_used[rq.num - 1] = (rq.act == ACT_MARK_USED);
					else
						block_used[rq.num - 1] = (rq.act == ACT_MARK_USED);
				end
			end
		end else if (rq.act == ACT_FIND) begin
			// first fit, inode search starts at the first usable index
			k = rq.sel ? int'(first_inode_q) : 0;
			while (k < span && rsp.found == 0) begin
				if (!(rq.sel ? inode_used[k] : block_used[k]))
					rsp.found = NUM_W'(k + 1);
				k++;
			end
		end
		rsp.free_blk = free_blocks_q;
		rsp.free_ino = free_inodes_q;
		return rsp;
	endfunction

	// Random request: mostly in-range marks and finds, some zero, out-of-range and noise
	function automatic alloc_req_t make_request(int used_pct);
		alloc_req_t rq;
		int         span;
		int         pick;
		rq.sel = 1'($urandom_range(0, 1));
		span = map_span(rq.sel);
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			rq.act = ACT_W'($urandom_range(0, 3));
			rq.num = NUM_W'($urandom_range(0, 2047));
		end else if (pick < 28) begin
			rq.act = ACT_FIND;
			rq.num = NUM_W'($urandom_range(0, 2047));
		end else begin
			rq.act = ($urandom_range(0, 99) < used_pct) ? ACT_MARK_USED : ACT_MARK_FREE;
			pick = $urandom_range(0, 99);
			if (pick < 5)
				rq.num = '0;
			else if (pick < 15 || span == 0)
				rq.num = NUM_W'($urandom_range(span + 1, 2047));
			else
				rq.num = NUM_W'($urandom_range(1, span));
		end
		return rq;
	endfunction

	task automatic queue_req(logic [ACT_W-1:0] a, logic s, logic [NUM_W-1:0] n);
		alloc_req_t rq;
		rq.act = a;
		rq.sel = s;
		rq.num = n;
		request_queue.push_back(rq);
	endtask

	// Register write; only called while nothing is in flight
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [NUM_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_BLOCK_COUNT: begin
				block_count_q = data;
				free_blocks_q = data;
			end
			REG_INODE_COUNT: begin
				inode_count_q = data[ICNT_W-1:0];
				free_inodes_q = data[ICNT_W-1:0];
			end
			REG_FIRST_INODE: begin
				first_inode_q = data[FIRST_W-1:0];
			end
			default: begin
			end
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every word is sent and every reply is back
	task automatic wait_idle();
		do
			@(posedge clk);
		while (request_queue.size() != 0 || in_valid || replies_due.size() != 0);
	endtask

	task automatic run_random(int n, int used_pct);
		for (int i = 0; i < n; i++)
			request_queue.push_back(make_request(used_pct));
	endtask

	task automatic note_failure(string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("ERROR: %s", msg);
	endtask

	task automatic check_field(string name, logic [NUM_W-1:0] got, logic [NUM_W-1:0] exp_v);
		if (got !== exp_v)
			note_failure($sformatf("reply %0d %s: expected %0d, got %0d",
				reply_index, name, exp_v, got));
	endtask

	// Sender: send words in bursts, hold each word until it is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				replies_due.push_back(apply_request({action, map_select, item_number}));
			if (!in_valid || in_ready) begin
				send_now = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (request_queue.size() != 0) begin
					next_req = request_queue.pop_front();
					action <= next_req.act;
					map_select <= next_req.sel;
					item_number <= next_req.num;
					send_now = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
				in_valid <= send_now;
			end
		end
	end

	// Receiver: stall on a changing pattern, plus one long hold-off on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else if (hold_request && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
				ready_next = 1'b0;
			end else begin
				if (mode_left == 0) begin
					ready_mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 200);
				end else begin
					mode_left--;
				end
				case (ready_mode)
					0: ready_next = 1'b1;
					1: ready_next = 1'($urandom_range(0, 1));
					2: ready_next = ($urandom_range(0, 3) == 0);
					default: ready_next = ($urandom_range(0, 7) != 0);
				endcase
			end
			out_ready <= ready_next;
		end
	end

	// Compare each reply with the oldest outstanding one
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (replies_due.size() == 0) begin
				note_failure($sformatf("reply %0d arrived with nothing outstanding", reply_index));
			end else begin
				want = replies_due.pop_front();
				check_field("found_number", found_number, want.found);
				check_field("bit_was_set", NUM_W'(bit_was_set), NUM_W'(want.was_set));
				check_field("out_of_range", NUM_W'(out_of_range), NUM_W'(want.oor));
				check_field("free_blocks", free_blocks, want.free_blk);
				check_field("free_inodes", NUM_W'(free_inodes), NUM_W'(want.free_ino));
			end
			reply_index++;
		end
	end

	initial begin
		#1500000;
		$display("** bitmap_block_inode_allocator: FAILED **");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Reset configuration: 128 blocks, 32 inodes, search from inode index 11
		queue_req(ACT_FIND, 1'b0, 11'd0);
		queue_req(ACT_FIND, 1'b1, 11'd2047);
		queue_req(ACT_MARK_USED, 1'b0, 11'd1);
		queue_req(ACT_MARK_USED, 1'b0, 11'd1);
		queue_req(ACT_FIND, 1'b0, 11'd0);
		queue_req(ACT_MARK_USED, 1'b0, 11'd128);
		queue_req(ACT_MARK_USED, 1'b0, 11'd129);
		queue_req(ACT_MARK_USED, 1'b0, 11'd2047);
		queue_req(ACT_MARK_USED, 1'b0, 11'd0);
		queue_req(ACT_MARK_FREE, 1'b0, 11'd0);
		queue_req(ACT_MARK_FREE, 1'b0, 11'd1);
		queue_req(ACT_MARK_FREE, 1'b0, 11'd1);
		queue_req(ACT_MARK_FREE, 1'b0, 11'd2047);
		queue_req(ACT_NOP, 1'b0, 11'd2047);
		queue_req(ACT_NOP, 1'b1, 11'd5);
		queue_req(ACT_MARK_USED, 1'b1, 11'd12);
		queue_req(ACT_FIND, 1'b1, 11'd0);
		queue_req(ACT_MARK_USED, 1'b1, 11'd32);
		queue_req(ACT_MARK_USED, 1'b1, 11'd33);
		queue_req(ACT_MARK_FREE, 1'b1, 11'd32);
		queue_req(ACT_MARK_USED, 1'b1, 11'd1);
		queue_req(ACT_FIND, 1'b1, 11'd0);
		wait_idle();

		// Full-size maps; the receiver holds off once so the input backs up
		write_reg(REG_BLOCK_COUNT, 11'd1024);
		write_reg(REG_INODE_COUNT, 11'd256);
		write_reg(REG_FIRST_INODE, 11'd0);
		queue_req(ACT_MARK_USED, 1'b0, 11'd1024);
		queue_req(ACT_FIND, 1'b0, 11'd0);
		run_random(200, 60);
		hold_request = 1'b1;
		wait_idle();

		// Smallest maps
		write_reg(REG_BLOCK_COUNT, 11'd1);
		write_reg(REG_INODE_COUNT, 11'd1);
		run_random(60, 50);
		wait_idle();

		// Counts beyond the map depth, search start near the top
		write_reg(REG_BLOCK_COUNT, 11'd2047);
		write_reg(REG_INODE_COUNT, 11'd511);
		write_reg(REG_FIRST_INODE, 11'd255);
		queue_req(ACT_MARK_USED, 1'b0, 11'd1);
		queue_req(ACT_MARK_USED, 1'b1, 11'd256);
		wait_idle();
		// reload to all-ones with bits set, then free them: counters saturate
		write_reg(REG_BLOCK_COUNT, 11'd2047);
		write_reg(REG_INODE_COUNT, 11'd511);
		queue_req(ACT_MARK_FREE, 1'b0, 11'd1);
		queue_req(ACT_MARK_FREE, 1'b1, 11'd256);
		queue_req(ACT_FIND, 1'b1, 11'd0);
		queue_req(ACT_FIND, 1'b0, 11'd0);
		run_random(120, 50);
		wait_idle();

		// Empty maps: every nonzero mark is out of range, every find misses
		write_reg(REG_BLOCK_COUNT, 11'd0);
		write_reg(REG_INODE_COUNT, 11'd0);
		write_reg(REG_SPARE, 11'd5);
		run_random(40, 50);
		wait_idle();

		// Inode search starting past the end of the map
		write_reg(REG_INODE_COUNT, 11'd20);
		write_reg(REG_FIRST_INODE, 11'd30);
		write_reg(REG_BLOCK_COUNT, 11'd40);
		queue_req(ACT_FIND, 1'b1, 11'd0);
		run_random(60, 60);
		wait_idle();

		// Random phases, mostly small maps so they fill and drain
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if ($urandom_range(0, 5) == 0)
				write_reg(REG_BLOCK_COUNT, NUM_W'($urandom_range(0, 2047)));
			else
				write_reg(REG_BLOCK_COUNT, NUM_W'($urandom_range(1, 64)));
			if ($urandom_range(0, 5) == 0)
				write_reg(REG_INODE_COUNT, NUM_W'($urandom_range(0, 2047)));
			else
				write_reg(REG_INODE_COUNT, NUM_W'($urandom_range(1, 48)));
			if ($urandom_range(0, 5) == 0)
				write_reg(REG_FIRST_INODE, NUM_W'($urandom_range(0, 2047)));
			else
				write_reg(REG_FIRST_INODE, NUM_W'($urandom_range(0, 16)));
			run_random(130, (p % 2 == 0) ? 75 : 35);
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("** bitmap_block_inode_allocator: PASSED **");
		else
			$display("** bitmap_block_inode_allocator: FAILED **");
		$finish;
	end

endmodule
